@@ hw/rtl/clipped_line_rasterizer_top_defines.svh @@
//------------------------------------------------------------------------------
// clipped_line_rasterizer_top_defines.svh
// Assertion macros shared by the line rasterizer RTL.
//------------------------------------------------------------------------------
`ifndef CLIPPED_LINE_RASTERIZER_TOP_DEFINES_SVH
`define CLIPPED_LINE_RASTERIZER_TOP_DEFINES_SVH

// expression must hold at every clock edge out of reset
`define CLR_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define CLR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/clr_pkg.sv @@
//------------------------------------------------------------------------------
// clr_pkg
// Types and constants of the line rasterizer.
//------------------------------------------------------------------------------
package clr_pkg;

   localparam int COORD_BITS = 12;
   localparam int ADDR_BITS  = 20;
   localparam int COLOR_BITS = 32;
   localparam int DELTA_BITS = COORD_BITS + 1;
   localparam int DTWO_BITS  = COORD_BITS + 2;
   localparam int ERR_BITS   = 16;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_TICK = 1'b1;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic                  axes_swapped;
      coord_type             major_pos;
      coord_type             major_end;
      coord_type             minor_pos;
      logic                  minor_step_down;
      logic [DELTA_BITS-1:0] major_delta;
      logic [DTWO_BITS-1:0]  minor_delta_twice;
   } line_setup_type;

   typedef struct packed {
      coord_type             pixel_x;
      coord_type             pixel_y;
      logic [ADDR_BITS-1:0]  pixel_address;
      logic                  visible;
      logic [COLOR_BITS-1:0] pixel_color;
      logic                  last_pixel;
   } pixel_type;

endpackage

@@ hw/rtl/clr_setup.sv @@
//------------------------------------------------------------------------------
// clr_setup
// Line setup: steep test, axis swap, endpoint ordering and deltas.
//------------------------------------------------------------------------------
module clr_setup (
   input  clr_pkg::coord_type      start_x,
   input  clr_pkg::coord_type      start_y,
   input  clr_pkg::coord_type      end_x,
   input  clr_pkg::coord_type      end_y,
   output clr_pkg::line_setup_type setup
);
   import clr_pkg::*;

   logic signed [DELTA_BITS-1:0] diff_x;
   logic signed [DELTA_BITS-1:0] diff_y;
   logic [DELTA_BITS-1:0]        abs_dx;
   logic [DELTA_BITS-1:0]        abs_dy;
   logic                         steep;
   coord_type                    a_major, a_minor, b_major, b_minor;
   coord_type                    lo_major, lo_minor, hi_major, hi_minor;
   logic signed [DELTA_BITS-1:0] diff_minor;
   logic [DELTA_BITS-1:0]        abs_minor;

   always_comb begin
      diff_x = {start_x[COORD_BITS-1], start_x} - {end_x[COORD_BITS-1], end_x};
      diff_y = {start_y[COORD_BITS-1], start_y} - {end_y[COORD_BITS-1], end_y};
      abs_dx = diff_x[DELTA_BITS-1] ? DELTA_BITS'(-diff_x) : DELTA_BITS'(diff_x);
      abs_dy = diff_y[DELTA_BITS-1] ? DELTA_BITS'(-diff_y) : DELTA_BITS'(diff_y);
      // equal deltas keep x as the major axis
      steep  = abs_dx < abs_dy;

      a_major = steep ? start_y : start_x;
      a_minor = steep ? start_x : start_y;
      b_major = steep ? end_y   : end_x;
      b_minor = steep ? end_x   : end_y;

      if (a_major > b_major) begin
         lo_major = b_major;
         lo_minor = b_minor;
         hi_major = a_major;
         hi_minor = a_minor;
      end else begin
         lo_major = a_major;
         lo_minor = a_minor;
         hi_major = b_major;
         hi_minor = b_minor;
      end

      diff_minor = {hi_minor[COORD_BITS-1], hi_minor} - {lo_minor[COORD_BITS-1], lo_minor};
      abs_minor  = diff_minor[DELTA_BITS-1] ? DELTA_BITS'(-diff_minor)
                                            : DELTA_BITS'(diff_minor);

      setup.axes_swapped      = steep;
      setup.major_pos         = lo_major;
      setup.major_end         = hi_major;
      setup.minor_pos         = lo_minor;
      setup.minor_step_down   = diff_minor[DELTA_BITS-1] || (diff_minor == '0);
      setup.major_delta       = DELTA_BITS'({hi_major[COORD_BITS-1], hi_major}
                                          - {lo_major[COORD_BITS-1], lo_major});
      setup.minor_delta_twice = {abs_minor, 1'b0};
   end

endmodule

@@ hw/rtl/clr_engine.sv @@
//------------------------------------------------------------------------------
// clr_engine
// Line state registers, per-pixel clip and address, and the error-term step.
//------------------------------------------------------------------------------
module clr_engine #(
   parameter int SCREEN_WIDTH  = 960,
   parameter int SCREEN_HEIGHT = 640
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_fire,
   input  logic                           req_func,
   input  clr_pkg::line_setup_type        setup,
   input  logic [clr_pkg::COLOR_BITS-1:0] req_line_color,
   output logic                           push,
   output clr_pkg::pixel_type             pixel
);
   import clr_pkg::*;

   logic                         line_active_ff, line_active_in;
   logic                         axes_swapped_ff, axes_swapped_in;
   coord_type                    major_pos_ff, major_pos_in;
   coord_type                    major_end_ff, major_end_in;
   coord_type                    minor_pos_ff, minor_pos_in;
   logic                         step_down_ff, step_down_in;
   logic [DELTA_BITS-1:0]        major_delta_ff, major_delta_in;
   logic [DTWO_BITS-1:0]         minor_dtwo_ff, minor_dtwo_in;
   logic signed [ERR_BITS-1:0]   error_term_ff, error_term_in;
   logic [COLOR_BITS-1:0]        held_color_ff, held_color_in;

   coord_type                    px, py;
   logic [COORD_BITS-1:0]        px_u, py_u;
   logic                         vis;
   logic                         last;
   logic signed [ERR_BITS-1:0]   err_sum;

   always_comb begin
      px   = axes_swapped_ff ? minor_pos_ff : major_pos_ff;
      py   = axes_swapped_ff ? major_pos_ff : minor_pos_ff;
      px_u = px;
      py_u = py;
      vis  = !px[COORD_BITS-1] && (px < $signed(COORD_BITS'(SCREEN_WIDTH)))
          && !py[COORD_BITS-1] && (py < $signed(COORD_BITS'(SCREEN_HEIGHT)));
      last = major_pos_ff == major_end_ff;

      pixel.pixel_x       = px;
      pixel.pixel_y       = py;
      pixel.pixel_address = vis ? (ADDR_BITS'(px_u)
                                  + ADDR_BITS'(py_u) * ADDR_BITS'(SCREEN_WIDTH))
                                : '0;
      pixel.visible       = vis;
      pixel.pixel_color   = held_color_ff;
      pixel.last_pixel    = last;

      push = req_fire && (req_func == FUNC_TICK) && line_active_ff;

      err_sum = error_term_ff + $signed({2'b00, minor_dtwo_ff});

      line_active_in  = line_active_ff;
      axes_swapped_in = axes_swapped_ff;
      major_pos_in    = major_pos_ff;
      major_end_in    = major_end_ff;
      minor_pos_in    = minor_pos_ff;
      step_down_in    = step_down_ff;
      major_delta_in  = major_delta_ff;
      minor_dtwo_in   = minor_dtwo_ff;
      error_term_in   = error_term_ff;
      held_color_in   = held_color_ff;

      if (req_fire && (req_func == FUNC_LOAD)) begin
         // a load replaces whatever line is in flight
         line_active_in  = 1'b1;
         axes_swapped_in = setup.axes_swapped;
         major_pos_in    = setup.major_pos;
         major_end_in    = setup.major_end;
         minor_pos_in    = setup.minor_pos;
         step_down_in    = setup.minor_step_down;
         major_delta_in  = setup.major_delta;
         minor_dtwo_in   = setup.minor_delta_twice;
         error_term_in   = '0;
         held_color_in   = req_line_color;
      end else if (push) begin
         if (last) begin
            line_active_in = 1'b0;
         end else begin
            error_term_in = err_sum;
            if (err_sum > $signed({3'b000, major_delta_ff})) begin
               minor_pos_in  = step_down_ff ? minor_pos_ff - coord_type'(1)
                                            : minor_pos_ff + coord_type'(1);
               error_term_in = err_sum - $signed({2'b00, major_delta_ff, 1'b0});
            end
            major_pos_in = major_pos_ff + coord_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff  <= 1'b0;
         axes_swapped_ff <= 1'b0;
         major_pos_ff    <= '0;
         major_end_ff    <= '0;
         minor_pos_ff    <= '0;
         step_down_ff    <= 1'b0;
         major_delta_ff  <= '0;
         minor_dtwo_ff   <= '0;
         error_term_ff   <= '0;
         held_color_ff   <= '0;
      end else begin
         line_active_ff  <= line_active_in;
         axes_swapped_ff <= axes_swapped_in;
         major_pos_ff    <= major_pos_in;
         major_end_ff    <= major_end_in;
         minor_pos_ff    <= minor_pos_in;
         step_down_ff    <= step_down_in;
         major_delta_ff  <= major_delta_in;
         minor_dtwo_ff   <= minor_dtwo_in;
         error_term_ff   <= error_term_in;
         held_color_ff   <= held_color_in;
      end
   end

endmodule

@@ hw/rtl/clr_out_buf.sv @@
//------------------------------------------------------------------------------
// clr_out_buf
// Two-entry result buffer: output register plus skid register.
//------------------------------------------------------------------------------
`include "clipped_line_rasterizer_top_defines.svh"

module clr_out_buf (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  clr_pkg::pixel_type push_data,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output clr_pkg::pixel_type rsp_data
);
   import clr_pkg::*;

   logic      main_valid_ff, main_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   pixel_type main_ff, main_in;
   pixel_type skid_ff, skid_in;
   logic      pop;

   always_comb begin
      pop           = main_valid_ff && rsp_ready;
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;

      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else if (push) begin
            main_in = push_data;
         end else begin
            main_valid_in = 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff) begin
            // output stalled: park the transfer in the skid entry
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end else begin
            main_in       = push_data;
            main_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   assign room      = !skid_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_ff;

   `CLR_ASSERT_ALWAYS(a_skid_behind_main, clock, reset, !skid_valid_ff || main_valid_ff, "skid entry valid with empty output register")
   `CLR_ASSERT_ALWAYS(a_no_push_when_full, clock, reset, !(push && skid_valid_ff), "result pushed with both entries full")
   `CLR_ASSERT_NEXT(a_stall_fills_skid, clock, reset, main_valid_ff && !rsp_ready && push, skid_valid_ff && main_valid_ff, "stalled push not parked in skid entry")

endmodule

@@ hw/rtl/clipped_line_rasterizer_top.sv @@
//------------------------------------------------------------------------------
// clipped_line_rasterizer_top
// Integer line rasterizer with per-pixel screen clip and linear address.
//------------------------------------------------------------------------------
// One request transfer per clock while req_ready is high. A load (func 0) sets
// up the line in the cycle it is taken and returns nothing; each tick (func 1)
// on an active line returns one pixel, registered. The whole Bresenham step
// (error add, compare, minor step, clip and x + y * SCREEN_WIDTH address) is one
// register-to-register pass, so sustained rate is one pixel per clock while
// rsp_ready is high. A two-entry result buffer lets a request be taken while a
// pixel waits on rsp_ready; req_ready drops only while both entries are full.
module clipped_line_rasterizer_top #(
   parameter int SCREEN_WIDTH  = 960,
   parameter int SCREEN_HEIGHT = 640
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_func,
   input  clr_pkg::coord_type             req_start_x,
   input  clr_pkg::coord_type             req_start_y,
   input  clr_pkg::coord_type             req_end_x,
   input  clr_pkg::coord_type             req_end_y,
   input  logic [clr_pkg::COLOR_BITS-1:0] req_line_color,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output clr_pkg::coord_type             rsp_pixel_x,
   output clr_pkg::coord_type             rsp_pixel_y,
   output logic [clr_pkg::ADDR_BITS-1:0]  rsp_pixel_address,
   output logic                           rsp_visible,
   output logic [clr_pkg::COLOR_BITS-1:0] rsp_pixel_color,
   output logic                           rsp_last_pixel
);
   import clr_pkg::*;

   line_setup_type setup;
   pixel_type      pixel;
   pixel_type      rsp_data;
   logic           push;
   logic           room;
   logic           req_fire;

   assign req_ready = room;
   assign req_fire  = req_valid && room;

   clr_setup u_setup (
      .start_x (req_start_x),
      .start_y (req_start_y),
      .end_x   (req_end_x),
      .end_y   (req_end_y),
      .setup   (setup)
   );

   clr_engine #(
      .SCREEN_WIDTH  (SCREEN_WIDTH),
      .SCREEN_HEIGHT (SCREEN_HEIGHT)
   ) u_engine (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_func       (req_func),
      .setup          (setup),
      .req_line_color (req_line_color),
      .push           (push),
      .pixel          (pixel)
   );

   clr_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (pixel),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_pixel_x       = rsp_data.pixel_x;
   assign rsp_pixel_y       = rsp_data.pixel_y;
   assign rsp_pixel_address = rsp_data.pixel_address;
   assign rsp_visible       = rsp_data.visible;
   assign rsp_pixel_color   = rsp_data.pixel_color;
   assign rsp_last_pixel    = rsp_data.last_pixel;

endmodule
